// ----- hdl/ris_pkg.sv -----
package ris_pkg;

  // Field and register widths
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 1;

  // Multiplier blocks: 67x67 signed, split at bit 34
  localparam int unsigned MopW   = 67;
  localparam int unsigned MprodW = 2 * MopW;
  localparam int unsigned MulLoW = 34;
  localparam int unsigned MulHiW = MopW - MulLoW;

  // Divider: remainder/denominator width, quotient is unsigned Q1.32 up to 1.0
  localparam int unsigned DivW     = 132;
  localparam int unsigned QFrac    = 32;
  localparam int unsigned QW       = QFrac + 1;
  localparam int unsigned DivSteps = QFrac;

  // Stage numbers of the datapath
  localparam int unsigned StDb      = 1;
  localparam int unsigned StJ       = 4;
  localparam int unsigned StSum     = 7;
  localparam int unsigned StFlag    = 8;
  localparam int unsigned StDiv0    = 9;
  localparam int unsigned StDivLast = StDiv0 + DivSteps;
  localparam int unsigned StProd    = StDivLast + 1;
  localparam int unsigned StPt      = StProd + 1;
  localparam int unsigned Lat       = StPt + 3;

  typedef logic signed [CoordW-1:0]   coord_t;
  typedef logic signed [CoordW:0]     w33_t;
  typedef logic signed [65:0]         j_t;
  typedef logic signed [66:0]         bb_t;
  typedef logic signed [MopW-1:0]     mop_t;
  typedef logic signed [MprodW-1:0]   mprod_t;
  typedef logic [DivW-1:0]            dv_t;
  typedef logic [QW-1:0]              quo_t;
  typedef logic signed [2*CoordW+1:0] prod_t;
  typedef logic signed [CoordW+1:0]   pt_t;
  typedef logic signed [CoordW+2:0]   ed_t;
  typedef logic signed [73:0]         sq_t;

  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;
  localparam quo_t   QOne     = quo_t'(1) << QFrac;

  localparam logic [CfgW-1:0] CoplanarTolRst = 32'd45875;
  localparam logic [CfgW-1:0] SegmentTolRst  = 32'd66;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoplanarTol = 1'b0,
    CfgSegmentTol  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t direction_x;
    coord_t direction_y;
    coord_t direction_z;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_start_z;
    coord_t seg_end_x;
    coord_t seg_end_y;
    coord_t seg_end_z;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } out_item_t;

  // Clamp an exact coordinate to the Q16.16 range
  function automatic coord_t sat32(pt_t v);
    coord_t r;
    if (v > pt_t'(CoordMax)) begin
      r = CoordMax;
    end else if (v < pt_t'(CoordMin)) begin
      r = CoordMin;
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

endpackage

// ----- hdl/ris_if.sv -----
interface ris_in_if import ris_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ris_out_if import ris_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/ris_mul.sv -----
// Two-stage signed 67x67 multiplier: partial products, then final sum
module ris_mul import ris_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  mop_t   a_i,
  input  mop_t   b_i,
  output mprod_t p_o
);

  logic [MulLoW-1:0]                a_lo, b_lo;
  logic signed [MulHiW-1:0]         a_hi, b_hi;
  logic [2*MulLoW-1:0]              ll_d, ll_q;
  logic signed [MulLoW+MulHiW:0]    lh_d, lh_q, hl_d, hl_q;
  logic signed [2*MulHiW-1:0]       hh_d, hh_q;
  mprod_t                           p_d, p_q;

  assign a_lo = a_i[MulLoW-1:0];
  assign b_lo = b_i[MulLoW-1:0];
  assign a_hi = a_i[MopW-1:MulLoW];
  assign b_hi = b_i[MopW-1:MulLoW];

  // partial products
  assign ll_d = a_lo * b_lo;
  assign lh_d = $signed({1'b0, a_lo}) * b_hi;
  assign hl_d = a_hi * $signed({1'b0, b_lo});
  assign hh_d = a_hi * b_hi;

  // recombine
  assign p_d = (mprod_t'(hh_q) <<< (2 * MulLoW)) + (mprod_t'(lh_q) <<< MulLoW)
             + (mprod_t'(hl_q) <<< MulLoW) + mprod_t'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
      p_q  <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- hdl/ray_segment_intersect_core.sv -----
// Ray against line segment test in 3D, signed Q16.16. One transaction enters per clock
// while the output is not stalled. Most of the pipe is the 33-stage restoring divider that
// forms the ray parameter s, plus three rounds of multipliers (cross products, dot products,
// squared distances). The whole pipe holds while a finished result is not taken. The user
// must see that the two tolerances are written through the cfg port (index 0 coplanar,
// 1 segment) only while the block is idle; the block itself does not enforce this.
module ray_segment_intersect_core import ris_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  ris_in_if.sink             in_if,
  ris_out_if.source          out_if
);

  typedef struct {
    coord_t o  [3];
    coord_t d  [3];
    coord_t p1 [3];
    coord_t p2 [3];
  } side_t;

  typedef struct packed {
    logic rej;
    dv_t  r;
    dv_t  den;
    quo_t q;
  } div_t;

  // Configuration registers
  logic [CfgW-1:0] coplanar_tol_q, segment_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coplanar_tol_q <= CoplanarTolRst;
      segment_tol_q  <= SegmentTolRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgCoplanarTol: coplanar_tol_q <= cfg_data_i;
        CfgSegmentTol:  segment_tol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid chain
  logic           en;
  logic [Lat:1]   vld_q;

  assign en          = !vld_q[Lat] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-1:1], in_if.valid};
    end
  end

  // Raw coordinates ride along up to the point stage
  side_t side_in;
  side_t side_q [StDb:StPt];

  always_comb begin
    side_in.o[0]  = in_if.data.origin_x;
    side_in.o[1]  = in_if.data.origin_y;
    side_in.o[2]  = in_if.data.origin_z;
    side_in.d[0]  = in_if.data.direction_x;
    side_in.d[1]  = in_if.data.direction_y;
    side_in.d[2]  = in_if.data.direction_z;
    side_in.p1[0] = in_if.data.seg_start_x;
    side_in.p1[1] = in_if.data.seg_start_y;
    side_in.p1[2] = in_if.data.seg_start_z;
    side_in.p2[0] = in_if.data.seg_end_x;
    side_in.p2[1] = in_if.data.seg_end_y;
    side_in.p2[2] = in_if.data.seg_end_z;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[StDb] <= side_in;
      for (int k = StDb + 1; k <= StPt; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 1: segment direction db and offset dc
  w33_t db1_q [3];
  w33_t dc1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        db1_q[i] <= w33_t'(side_in.p2[i]) - w33_t'(side_in.p1[i]);
        dc1_q[i] <= w33_t'(side_in.p1[i]) - w33_t'(side_in.o[i]);
      end
    end
  end

  // Stages 2-3: cross products j = d x db and bb = dc x db
  mprod_t jm1 [3], jm2 [3], bm1 [3], bm2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int P = (i + 1) % 3;
    localparam int Q = (i + 2) % 3;
    ris_mul u_jm1 (.clk_i, .en_i(en), .a_i(mop_t'(side_q[StDb].d[P])),
                   .b_i(mop_t'(db1_q[Q])), .p_o(jm1[i]));
    ris_mul u_jm2 (.clk_i, .en_i(en), .a_i(mop_t'(side_q[StDb].d[Q])),
                   .b_i(mop_t'(db1_q[P])), .p_o(jm2[i]));
    ris_mul u_bm1 (.clk_i, .en_i(en), .a_i(mop_t'(dc1_q[P])),
                   .b_i(mop_t'(db1_q[Q])), .p_o(bm1[i]));
    ris_mul u_bm2 (.clk_i, .en_i(en), .a_i(mop_t'(dc1_q[Q])),
                   .b_i(mop_t'(db1_q[P])), .p_o(bm2[i]));
  end

  // Stage 4: differences
  j_t   j4_q  [3];
  bb_t  bb4_q [3];
  w33_t dc4   [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        j4_q[i]  <= j_t'(jm1[i] - jm2[i]);
        bb4_q[i] <= bb_t'(bm1[i] - bm2[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dc4[i] = w33_t'(side_q[StJ].p1[i]) - w33_t'(side_q[StJ].o[i]);
    end
  end

  // Stages 5-6: triple product, denominator and numerator terms
  mprod_t tm [3], em [3], nm [3];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    ris_mul u_tm (.clk_i, .en_i(en), .a_i(mop_t'(dc4[i])), .b_i(mop_t'(j4_q[i])),
                  .p_o(tm[i]));
    ris_mul u_em (.clk_i, .en_i(en), .a_i(mop_t'(j4_q[i])), .b_i(mop_t'(j4_q[i])),
                  .p_o(em[i]));
    ris_mul u_nm (.clk_i, .en_i(en), .a_i(mop_t'(bb4_q[i])), .b_i(mop_t'(j4_q[i])),
                  .p_o(nm[i]));
  end

  // Stage 7: dot product sums
  mprod_t trip7_q, den7_q, num7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      trip7_q <= tm[0] + tm[1] + tm[2];
      den7_q  <= em[0] + em[1] + em[2];
      num7_q  <= nm[0] + nm[1] + nm[2];
    end
  end

  // Stage 8: rejection tests (not coplanar, parallel, s outside [0,1])
  mprod_t trip_abs;
  logic   rej8_d, rej8_q;
  dv_t    num8_q, den8_q;

  assign trip_abs = trip7_q[MprodW-1] ? -trip7_q : trip7_q;
  assign rej8_d   = (trip_abs >= mprod_t'({coplanar_tol_q, 32'b0}))
                 || (den7_q == '0) || (num7_q < 0) || (num7_q > den7_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rej8_q <= rej8_d;
      num8_q <= dv_t'(num7_q);
      den8_q <= dv_t'(den7_q);
    end
  end

  // Stages 9-41: restoring division, one quotient bit per stage
  div_t div_src [0:DivSteps];
  div_t div_q   [0:DivSteps];

  function automatic div_t div_step(div_t s);
    div_t n;
    logic ge;
    ge    = s.r >= s.den;
    n.rej = s.rej;
    n.den = s.den;
    n.r   = ge ? s.r - s.den : s.r;
    n.q   = {s.q[QW-2:0], ge};
    return n;
  endfunction

  assign div_src[0] = '{rej: rej8_q, r: num8_q, den: den8_q, q: '0};

  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    assign div_src[k] = '{rej: div_q[k-1].rej, r: {div_q[k-1].r[DivW-2:0], 1'b0},
                          den: div_q[k-1].den, q: div_q[k-1].q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= DivSteps; k++) begin
        div_q[k] <= div_step(div_src[k]);
      end
    end
  end

  // Stage 42: s * d
  prod_t prod42_q [3];
  logic  rej42_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rej42_q <= div_q[DivSteps].rej;
      for (int i = 0; i < 3; i++) begin
        prod42_q[i] <= $signed({1'b0, div_q[DivSteps].q}) * side_q[StDivLast].d[i];
      end
    end
  end

  // Stage 43: intersection point, floor of the product, exact width
  pt_t  pt43_q [3], pt44_q [3], pt45_q [3];
  logic rej43_q, rej44_q, rej45_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rej43_q <= rej42_q;
      rej44_q <= rej43_q;
      rej45_q <= rej44_q;
      for (int i = 0; i < 3; i++) begin
        pt43_q[i] <= pt_t'(side_q[StProd].o[i]) + pt_t'(prod42_q[i] >>> QFrac);
        pt44_q[i] <= pt43_q[i];
        pt45_q[i] <= pt44_q[i];
      end
    end
  end

  // Stages 44-45: squared distances to both endpoints and segment length
  ed_t    e1 [3], e2 [3], eb [3];
  mprod_t s1 [3], s2 [3], sb [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = ed_t'(pt43_q[i]) - ed_t'(side_q[StPt].p1[i]);
      e2[i] = ed_t'(pt43_q[i]) - ed_t'(side_q[StPt].p2[i]);
      eb[i] = ed_t'(side_q[StPt].p2[i]) - ed_t'(side_q[StPt].p1[i]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    ris_mul u_s1 (.clk_i, .en_i(en), .a_i(mop_t'(e1[i])), .b_i(mop_t'(e1[i])),
                  .p_o(s1[i]));
    ris_mul u_s2 (.clk_i, .en_i(en), .a_i(mop_t'(e2[i])), .b_i(mop_t'(e2[i])),
                  .p_o(s2[i]));
    ris_mul u_sb (.clk_i, .en_i(en), .a_i(mop_t'(eb[i])), .b_i(mop_t'(eb[i])),
                  .p_o(sb[i]));
  end

  // Stage 46: segment bounds test and output register
  sq_t       lhs, rhs;
  logic      hit;
  out_item_t out_d, out_q;

  assign lhs = sq_t'(s1[0] + s1[1] + s1[2] + s2[0] + s2[1] + s2[2]);
  assign rhs = sq_t'(sb[0] + sb[1] + sb[2]) + sq_t'({segment_tol_q, 16'b0});
  assign hit = !rej45_q && (lhs <= rhs);

  always_comb begin
    out_d.hit     = hit;
    out_d.point_x = hit ? sat32(pt45_q[0]) : '0;
    out_d.point_y = hit ? sat32(pt45_q[1]) : '0;
    out_d.point_z = hit ? sat32(pt45_q[2]) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid = vld_q[Lat];
  assign out_if.data  = out_q;

  // Checks
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid chain moved during stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> vld_q[StDb])
    else $error("accepted transaction not in first stage");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StDivLast] && !div_q[DivSteps].rej |-> div_q[DivSteps].r < div_q[DivSteps].den)
    else $error("divider remainder not below denominator");

  a_div_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StDivLast] && !div_q[DivSteps].rej |-> div_q[DivSteps].q <= QOne)
    else $error("ray parameter above one");

endmodule

// ----- tb/ray_segment_intersect_core_tb.sv -----
`timescale 1ns / 1ps

module ray_segment_intersect_core_tb;
  import ris_pkg::*;

  typedef logic signed [255:0] wide_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]  cfg_data_i;

  ris_in_if  in_if ();
  ris_out_if out_if ();

  ray_segment_intersect_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // Shadow copy of the tolerance registers
  logic [CfgW-1:0] coplanar_tol;
  logic [CfgW-1:0] segment_tol;

  in_item_t  ray_pending[$];
  out_item_t hit_expected[$];
  int        error_cnt;
  logic      in_accepted;
  int        burst_left;
  int        gap_left;
  int        stall_mode;
  int        stall_mode_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic wide_t dot3(input wide_t a[3], input wide_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Exact wide-integer intersection test; only s and s*D are rounded
  function automatic out_item_t predict_intersection(input in_item_t it);
    wide_t o[3], d[3], p1[3], p2[3], db[3], dc[3], jv[3], bv[3], pt[3], e1[3], e2[3];
    wide_t trip, den, num, q, lhs, rhs;
    out_item_t r;
    r = '0;
    o  = '{wide_t'(it.origin_x), wide_t'(it.origin_y), wide_t'(it.origin_z)};
    d  = '{wide_t'(it.direction_x), wide_t'(it.direction_y), wide_t'(it.direction_z)};
    p1 = '{wide_t'(it.seg_start_x), wide_t'(it.seg_start_y), wide_t'(it.seg_start_z)};
    p2 = '{wide_t'(it.seg_end_x), wide_t'(it.seg_end_y), wide_t'(it.seg_end_z)};
    for (int i = 0; i < 3; i++) begin
      db[i] = p2[i] - p1[i];
      dc[i] = p1[i] - o[i];
    end
    for (int i = 0; i < 3; i++) begin
      jv[i] = d[(i+1)%3] * db[(i+2)%3] - d[(i+2)%3] * db[(i+1)%3];
      bv[i] = dc[(i+1)%3] * db[(i+2)%3] - dc[(i+2)%3] * db[(i+1)%3];
    end
    // not coplanar
    trip = dot3(dc, jv);
    if (trip < 0) trip = -trip;
    if (trip >= (wide_t'(coplanar_tol) <<< 32)) return r;
    // parallel ray
    den = dot3(jv, jv);
    if (den == 0) return r;
    // parameter outside [0, 1]
    num = dot3(bv, jv);
    if (num < 0 || num > den) return r;
    q = (num <<< 32) / den;
    for (int i = 0; i < 3; i++) pt[i] = o[i] + ((q * d[i]) >>> 32);
    for (int i = 0; i < 3; i++) begin
      e1[i] = pt[i] - p1[i];
      e2[i] = pt[i] - p2[i];
    end
    lhs = dot3(e1, e1) + dot3(e2, e2);
    rhs = dot3(db, db) + wide_t'(segment_tol) * 65536;
    if (lhs > rhs) return r;
    r.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (pt[i] > wide_t'(CoordMax)) pt[i] = wide_t'(CoordMax);
      else if (pt[i] < wide_t'(CoordMin)) pt[i] = wide_t'(CoordMin);
    end
    r.point_x = coord_t'(pt[0]);
    r.point_y = coord_t'(pt[1]);
    r.point_z = coord_t'(pt[2]);
    return r;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic longint rand_span(input int mag);
    return longint'($urandom_range(0, 2 * mag)) - longint'(mag);
  endfunction

  // Ray built to pass exactly through a point of the segment
  function automatic in_item_t make_crossing_ray();
    in_item_t it;
    longint p1[3], db[3], dir[3], ip[3];
    int mag, k, ks;
    mag = 1 << $urandom_range(4, 27);
    k   = $urandom_range(0, 4);
    ks  = $urandom_range(0, 4);
    for (int i = 0; i < 3; i++) begin
      p1[i]  = rand_span(mag);
      db[i]  = rand_span(mag / 4) * 4;
      dir[i] = rand_span(mag / 4) * 4;
      ip[i]  = p1[i] + db[i] * k / 4;
    end
    it.seg_start_x = coord_t'(p1[0]);
    it.seg_start_y = coord_t'(p1[1]);
    it.seg_start_z = coord_t'(p1[2]);
    it.seg_end_x   = coord_t'(p1[0] + db[0]);
    it.seg_end_y   = coord_t'(p1[1] + db[1]);
    it.seg_end_z   = coord_t'(p1[2] + db[2]);
    it.direction_x = coord_t'(dir[0]);
    it.direction_y = coord_t'(dir[1]);
    it.direction_z = coord_t'(dir[2]);
    it.origin_x    = coord_t'(ip[0] - dir[0] * ks / 4);
    it.origin_y    = coord_t'(ip[1] - dir[1] * ks / 4);
    it.origin_z    = coord_t'(ip[2] - dir[2] * ks / 4);
    return it;
  endfunction

  function automatic in_item_t make_noise_ray();
    in_item_t it;
    logic [CoordW*12-1:0] bits;
    int sel;
    sel = $urandom_range(0, 2);
    if (sel == 0) begin
      for (int i = 0; i < 12; i++) bits[i*CoordW +: CoordW] = $urandom;
      it = in_item_t'(bits);
    end else begin
      // broken crossing: perturb one coordinate a little or a lot
      it = make_crossing_ray();
      bits = it;
      sel = $urandom_range(0, 11);
      if ($urandom_range(0, 1)) bits[sel*CoordW +: CoordW] ^= CoordW'($urandom_range(1, 255));
      else bits[sel*CoordW +: CoordW] = $urandom;
      it = in_item_t'(bits);
    end
    return it;
  endfunction

  task automatic write_cfg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CfgCoplanarTol) coplanar_tol = val;
    else segment_tol = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Let everything in flight drain, then some latency margin
  task automatic drain();
    while (ray_pending.size() != 0 || in_if.valid || hit_expected.size() != 0)
      @(posedge clk_i);
    repeat (Lat + 20) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) ray_pending.push_back(make_crossing_ray());
      else ray_pending.push_back(make_noise_ray());
    end
  endtask

  // Drive inputs at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_accepted)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (ray_pending.size() != 0) begin
        in_if.data  <= ray_pending.pop_front();
        in_if.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    // receiver stall pattern: always ready, light stalls or heavy stalls
    if (stall_mode_left == 0) begin
      stall_mode      <= $urandom_range(0, 2);
      stall_mode_left <= $urandom_range(10, 80);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      default: out_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Record accepted input transactions and their predicted results
  always @(posedge clk_i) begin
    in_accepted <= in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) hit_expected.push_back(predict_intersection(in_if.data));
  end

  // Check output transactions at the rising edge
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (out_if.valid && out_if.ready) begin
      if (hit_expected.size() == 0) begin
        report_mismatch("result with no pending expectation");
      end else begin
        exp_r = hit_expected.pop_front();
        if (out_if.data.hit !== exp_r.hit)
          report_mismatch($sformatf("hit %0b exp %0b", out_if.data.hit, exp_r.hit));
        if (out_if.data.point_x !== exp_r.point_x)
          report_mismatch($sformatf("point_x %h exp %h", out_if.data.point_x, exp_r.point_x));
        if (out_if.data.point_y !== exp_r.point_y)
          report_mismatch($sformatf("point_y %h exp %h", out_if.data.point_y, exp_r.point_y));
        if (out_if.data.point_z !== exp_r.point_z)
          report_mismatch($sformatf("point_z %h exp %h", out_if.data.point_z, exp_r.point_z));
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    in_item_t it;
    error_cnt       = 0;
    coplanar_tol    = CoplanarTolRst;
    segment_tol     = SegmentTolRst;
    burst_left      = 1;
    gap_left        = 0;
    stall_mode      = 0;
    stall_mode_left = 0;
    in_accepted     = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgCoplanarTol;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.data      = '0;
    out_if.ready    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (Lat + 5) @(posedge clk_i);

    // Directed: extremes, parallel, out of range, crossings
    ray_pending.push_back('0);
    ray_pending.push_back({12{CoordMax}});
    ray_pending.push_back({12{CoordMin}});
    it = '0;
    it.direction_x = 32'sh0001_0000;
    it.seg_start_x = 32'sh0002_0000;
    it.seg_end_x   = 32'sh0005_0000;
    ray_pending.push_back(it);                 // parallel ray on the same line
    it = '0;
    it.direction_x = 32'sh0001_0000;
    it.seg_start_y = 32'sh0001_0000;
    it.seg_end_y   = -32'sh0001_0000;
    ray_pending.push_back(it);                 // s = 0 exactly, hits segment middle
    it.seg_start_x = 32'sh0000_8000;
    it.seg_end_x   = 32'sh0000_8000;
    ray_pending.push_back(it);                 // s = 1/2
    it.seg_start_x = -32'sh0001_0000;
    it.seg_end_x   = -32'sh0001_0000;
    ray_pending.push_back(it);                 // s < 0
    it.seg_start_x = 32'sh0003_0000;
    it.seg_end_x   = 32'sh0003_0000;
    ray_pending.push_back(it);                 // s > 1
    it.seg_start_z = 32'sh0010_0000;
    it.seg_end_z   = 32'sh0010_0000;
    ray_pending.push_back(it);                 // not coplanar
    it = '0;
    it.direction_x = 32'sh0001_0000;
    it.seg_start_y = 32'sh0001_0000;
    it.seg_start_x = 32'sh0000_8000;
    it.seg_end_y   = 32'sh0003_0000;
    it.seg_end_x   = 32'sh0000_8000;
    ray_pending.push_back(it);                 // line crossing outside the segment
    it = '0;
    it.origin_x    = CoordMax;
    it.direction_x = CoordMax;
    it.seg_start_x = CoordMax;
    it.seg_start_y = CoordMax;
    it.seg_end_x   = CoordMax;
    it.seg_end_y   = CoordMin;
    ray_pending.push_back(it);                 // large coordinates near saturation
    it.origin_x    = CoordMin;
    it.direction_x = CoordMin;
    it.seg_start_x = CoordMin;
    it.seg_end_x   = CoordMin;
    ray_pending.push_back(it);
    for (int i = 0; i < 8; i++) ray_pending.push_back(make_crossing_ray());
    drain();

    // Saturation needs slack: maximum segment and coplanar tolerances
    write_cfg(CfgSegmentTol, '1);
    write_cfg(CfgCoplanarTol, '1);
    it = '0;
    it.origin_x    = CoordMax - 32'sh0000_8000;
    it.direction_x = 32'sh0001_0000;
    it.seg_start_x = CoordMax;
    it.seg_start_y = 32'sh0000_0100;
    it.seg_end_x   = CoordMax;
    it.seg_end_y   = -32'sh0000_0100;
    ray_pending.push_back(it);
    it.origin_x    = CoordMin + 32'sh0000_8000;
    it.direction_x = -32'sh0001_0000;
    it.seg_start_x = CoordMin;
    it.seg_end_x   = CoordMin;
    ray_pending.push_back(it);
    random_phase(100);
    drain();

    write_cfg(CfgCoplanarTol, '0);
    write_cfg(CfgSegmentTol, '0);
    random_phase(100);
    drain();

    write_cfg(CfgCoplanarTol, CoplanarTolRst);
    write_cfg(CfgSegmentTol, SegmentTolRst);
    random_phase(150);
    drain();

    write_cfg(CfgCoplanarTol, $urandom);
    write_cfg(CfgSegmentTol, $urandom_range(0, 1 << 20));
    random_phase(100);
    drain();

    write_cfg(CfgCoplanarTol, $urandom_range(1, 1 << 16));
    write_cfg(CfgSegmentTol, '1);
    random_phase(150);
    drain();

    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
